### hdl/kht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kht_pkg: shared types and constants of the keyword hash table
// Status codes, controller states, and the command and status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package kht_pkg;

   // default sizing, handed down from the top level
   localparam int DEF_MAX_SLOTS     = 64;
   localparam int DEF_MAX_KEY_BYTES = 8;
   localparam int DEF_TOKEN_BITS    = 8;

   // fixed field widths
   localparam int CAP_LOG2_W   = 3;
   localparam int KEY_BYTE_W   = 8;
   localparam int TOKEN_W      = 8;
   localparam int SLOT_IDX_W   = 6;
   localparam int KEY_LEN_W    = 4;
   localparam int HASH_W       = 64;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CAP_LOG2_W-1:0] CAP_LOG2_RESET = 3'd6;

   // FNV-1a 64-bit constants; the prime is 2^40 + 0x1b3
   localparam logic [HASH_W-1:0] HASH_BASIS = 64'hcbf2_9ce4_8422_2325;
   localparam logic [HASH_W-1:0] HASH_PRIME = 64'h0000_0100_0000_01b3;

   // register word indexes on the configuration port
   localparam logic REG_CAP_LOG2 = 1'b0;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_TOO_LONG  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SETUP,
      S_READ,
      S_CHECK
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       absorb;      // fold accepted byte into hash and key
      logic       key_clear;   // restart key accumulation
      logic       probe_init;  // load home slot, probe count zero
      logic       probe_step;  // advance to next quadratic probe
      logic       rd_en;       // read slot at probe index
      logic       ins_write;   // write entry at probe index
      logic       clr_write;   // clearing pass: invalidate one slot
      logic       rsp_load;    // register a result
      status_type rsp_status;
      logic       rsp_token;   // result carries stored token
      logic       rsp_slot;    // result carries slot index
   } kht_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic len_over;    // current byte overflows the key buffer
      logic op_insert;   // latched operation is insert
      logic slot_valid;  // slot read last cycle holds an entry
      logic key_match;   // slot read last cycle matches the key
      logic probe_last;  // current probe is the final one
      logic clr_done;    // clearing pass on its final slot
   } kht_sts_type;

endpackage : kht_pkg
`default_nettype wire

### hdl/kht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module kht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : kht_ram
`default_nettype wire

### hdl/kht_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kht_datapath: hash, key buffer, probe sequencer, slot stores, result
// Folds key bytes into the FNV-1a hash, walks the quadratic probe sequence
// and compares stored entries under command of the controller.
// ----------------------------------------------------------------------------
module kht_datapath #(
   parameter int MAX_SLOTS     = kht_pkg::DEF_MAX_SLOTS,
   parameter int MAX_KEY_BYTES = kht_pkg::DEF_MAX_KEY_BYTES,
   parameter int TOKEN_BITS    = kht_pkg::DEF_TOKEN_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_operation,
   input  wire logic [kht_pkg::KEY_BYTE_W-1:0]    req_key_byte,
   input  wire logic [kht_pkg::TOKEN_W-1:0]       req_token_value,
   input  wire logic [kht_pkg::CAP_LOG2_W-1:0]    cap_log2,
   input  wire kht_pkg::kht_cmd_type              cmd,
   output kht_pkg::kht_sts_type                   sts,
   output logic                                   rsp_valid,
   output logic [1:0]                             rsp_status,
   output logic [kht_pkg::TOKEN_W-1:0]            rsp_token_result,
   output logic [kht_pkg::SLOT_IDX_W-1:0]         rsp_slot_index
);
   import kht_pkg::*;

   localparam int SLOT_W   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int MAX_LOG2 = $clog2(MAX_SLOTS + 1) - 1;
   localparam int KEY_W    = KEY_BYTE_W * MAX_KEY_BYTES;
   localparam int ENTRY_W  = KEY_LEN_W + KEY_W + TOKEN_BITS;

   localparam logic [KEY_LEN_W-1:0] LEN_MAX  = KEY_LEN_W'(MAX_KEY_BYTES);
   localparam logic [KEY_LEN_W-1:0] LEN_OVER = KEY_LEN_W'(MAX_KEY_BYTES + 1);
   localparam logic [SLOT_W-1:0]    CLR_LAST = SLOT_W'(MAX_SLOTS - 1);

   // FNV-1a step; multiply by the prime as shifted adds
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [KEY_BYTE_W-1:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ HASH_W'(b);
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

   logic [HASH_W-1:0]                        hash_ff, hash_in;
   logic [MAX_KEY_BYTES-1:0][KEY_BYTE_W-1:0] key_ff, key_in;
   logic [KEY_LEN_W-1:0]                     len_ff, len_in;
   logic                                     op_ff;
   logic [TOKEN_BITS-1:0]                    tok_ff;
   logic [SLOT_W-1:0]                        idx_ff, idx_in;
   logic [SLOT_W-1:0]                        k_ff, k_in;
   logic [SLOT_W-1:0]                        clr_ff, clr_in;
   logic [3:0]                               cap_eff;
   logic [SLOT_W-1:0]                        mask;
   logic [SLOT_W-1:0]                        step_w;

   logic                                     vld_wr_en, vld_wr_data, vld_rd;
   logic [SLOT_W-1:0]                        vld_wr_addr;
   logic [ENTRY_W-1:0]                       ent_wr_data, ent_rd;
   logic [KEY_LEN_W-1:0]                     ent_len;
   logic [KEY_W-1:0]                         ent_key;
   logic [TOKEN_BITS-1:0]                    ent_tok;

   logic                                     rsp_valid_ff;
   status_type                               rsp_status_ff;
   logic [TOKEN_W-1:0]                       rsp_token_ff;
   logic [SLOT_IDX_W-1:0]                    rsp_slot_ff;

   // capacity clamped to the slots that exist
   assign cap_eff = (4'(cap_log2) > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : 4'(cap_log2);
   assign mask    = ~({SLOT_W{1'b1}} << cap_eff);
   // k^2 to (k+1)^2 adds 2k+1
   assign step_w  = SLOT_W'({k_ff, 1'b1});

   // key accumulation
   always_comb begin
      hash_in = hash_ff;
      key_in  = key_ff;
      len_in  = len_ff;
      if (cmd.key_clear) begin
         hash_in = HASH_BASIS;
         key_in  = '0;
         len_in  = '0;
      end else if (cmd.absorb) begin
         if (len_ff < LEN_MAX) begin
            hash_in = fnv_step(hash_ff, req_key_byte);
            for (int i = 0; i < MAX_KEY_BYTES; i++) begin
               if (len_ff == KEY_LEN_W'(i)) begin
                  key_in[i] = req_key_byte;
               end
            end
            len_in = len_ff + 1'b1;
         end else begin
            len_in = LEN_OVER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= HASH_BASIS;
         key_ff  <= '0;
         len_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         key_ff  <= key_in;
         len_ff  <= len_in;
      end
   end

   // operation and token as sampled on the last byte
   always_ff @(posedge clock) begin
      if (cmd.absorb) begin
         op_ff  <= req_operation;
         tok_ff <= TOKEN_BITS'(req_token_value);
      end
   end

   // probe sequencer and clearing counter
   always_comb begin
      idx_in = idx_ff;
      k_in   = k_ff;
      if (cmd.probe_init) begin
         idx_in = hash_ff[SLOT_W-1:0] & mask;
         k_in   = '0;
      end else if (cmd.probe_step) begin
         idx_in = (idx_ff + step_w) & mask;
         k_in   = k_ff + 1'b1;
      end
      clr_in = cmd.clr_write ? clr_ff + 1'b1 : clr_ff;
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      k_ff   <= k_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // slot stores: valid bits swept clear after reset, entries left as they are
   assign vld_wr_en   = cmd.clr_write | cmd.ins_write;
   assign vld_wr_addr = cmd.clr_write ? clr_ff : idx_ff;
   assign vld_wr_data = ~cmd.clr_write;
   assign ent_wr_data = {len_ff, KEY_W'(key_ff), tok_ff};

   kht_ram #(
      .WIDTH (1),
      .DEPTH (MAX_SLOTS)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_wr_en),
      .wr_addr (vld_wr_addr),
      .wr_data (vld_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (vld_rd)
   );

   kht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.ins_write),
      .wr_addr (idx_ff),
      .wr_data (ent_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (ent_rd)
   );

   assign {ent_len, ent_key, ent_tok} = ent_rd;

   // status back to the controller
   always_comb begin
      sts.len_over   = (len_ff >= LEN_MAX);
      sts.op_insert  = op_ff;
      sts.slot_valid = vld_rd;
      sts.key_match  = (ent_len == len_ff) && (ent_key == KEY_W'(key_ff));
      sts.probe_last = (k_ff == mask);
      sts.clr_done   = (clr_ff == CLR_LAST);
   end

   // result register, one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_token_ff  <= cmd.rsp_token ? TOKEN_W'(ent_tok) : '0;
         rsp_slot_ff   <= cmd.rsp_slot ? SLOT_IDX_W'(idx_ff) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_token_result = rsp_token_ff;
   assign rsp_slot_index   = rsp_slot_ff;

   // a step is never issued past the final probe
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.probe_step |-> (k_ff != mask))
      else $error("probe step issued past the final probe");

endmodule : kht_datapath
`default_nettype wire

### hdl/kht_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kht_ctrl: sequencing state machine of the keyword hash table
// Runs the clearing pass, takes key bytes and steps the probe loop,
// deciding each probe from the status of the datapath.
// ----------------------------------------------------------------------------
module kht_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_last_byte,
   input  wire kht_pkg::kht_sts_type sts,
   output kht_pkg::kht_cmd_type      cmd,
   output logic                      busy
);
   import kht_pkg::*;

   state_type state_ff, state_in;
   logic      accept;
   logic      finish;

   assign accept = start && (state_ff == S_IDLE);

   // probe outcome: the walk ends on this slot
   always_comb begin
      if (sts.op_insert) begin
         finish = !sts.slot_valid || sts.probe_last;
      end else begin
         finish = !sts.slot_valid || sts.key_match || sts.probe_last;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && req_last_byte && !sts.len_over) begin
               state_in = S_SETUP;
            end
         end
         S_SETUP: state_in = S_READ;
         S_READ:  state_in = S_CHECK;
         S_CHECK: state_in = finish ? S_IDLE : S_READ;
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // outputs
   always_comb begin
      cmd            = '0;
      cmd.rsp_status = ST_OK;
      busy           = (state_ff != S_IDLE);
      unique case (state_ff)
         S_CLEAR: cmd.clr_write = 1'b1;
         S_IDLE: begin
            if (accept) begin
               cmd.absorb = 1'b1;
               if (req_last_byte && sts.len_over) begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_TOO_LONG;
                  cmd.key_clear  = 1'b1;
               end
            end
         end
         S_SETUP: cmd.probe_init = 1'b1;
         S_READ:  cmd.rd_en      = 1'b1;
         S_CHECK: begin
            if (finish) begin
               cmd.rsp_load  = 1'b1;
               cmd.key_clear = 1'b1;
               if (sts.op_insert) begin
                  if (!sts.slot_valid) begin
                     cmd.ins_write  = 1'b1;
                     cmd.rsp_status = ST_OK;
                     cmd.rsp_slot   = 1'b1;
                  end else begin
                     cmd.rsp_status = ST_FULL;
                  end
               end else if (sts.slot_valid && sts.key_match) begin
                  cmd.rsp_status = ST_OK;
                  cmd.rsp_token  = 1'b1;
                  cmd.rsp_slot   = 1'b1;
               end else begin
                  cmd.rsp_status = ST_NOT_FOUND;
               end
            end else begin
               cmd.probe_step = 1'b1;
            end
         end
         default: cmd.clr_write = 1'b0;
      endcase
   end

   // an entry is only written into a free slot
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_write |-> (state_ff == S_CHECK) && !sts.slot_valid)
      else $error("entry written over an occupied slot");

   // every result returns the controller to idle
   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> (state_ff == S_IDLE))
      else $error("controller not idle after a result");

   // a final byte of a key that fits starts a probe walk
   a_last_probes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte && !sts.len_over) |=> (state_ff == S_SETUP))
      else $error("final byte did not start probing");

endmodule : kht_ctrl
`default_nettype wire

### hdl/keyword_hash_table_lookup_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_hash_table_lookup_top: FNV-1a keyword table, quadratic probing
// Key bytes enter one per transaction; the final byte runs a lookup or an
// insert and produces one result.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive req_* and raise start; a transaction is taken on a rising
//    edge with start high and busy low. Each non-final key byte gives no
//    result; busy stays low, so bytes go back to back.
//  - The final byte (req_last_byte high) starts the probe walk: a setup
//    state, then per probe a registered slot read and then a compare.
//    The result strobe rsp_valid rises as busy falls.
//  - An over-long key is answered with no probe: rsp_valid rises on the
//    edge that takes its final byte, and busy stays low.
//  - Results stand on rsp_* for exactly one cycle; the receiver cannot
//    hold them off, and the next transaction may be taken in that cycle.
//  - Reset clears the key accumulator and sweeps all MAX_SLOTS valid bits
//    clear (64 by default) with busy high; APB takes writes throughout.
//  - capacity_log2 is at byte address 0; the user must write it only
//    while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module keyword_hash_table_lookup_top #(
   parameter int MAX_SLOTS     = kht_pkg::DEF_MAX_SLOTS,
   parameter int MAX_KEY_BYTES = kht_pkg::DEF_MAX_KEY_BYTES,
   parameter int TOKEN_BITS    = kht_pkg::DEF_TOKEN_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic [kht_pkg::KEY_BYTE_W-1:0] req_key_byte,
   input  wire logic                           req_last_byte,
   input  wire logic [kht_pkg::TOKEN_W-1:0]    req_token_value,
   // result channel
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_status,
   output logic [kht_pkg::TOKEN_W-1:0]         rsp_token_result,
   output logic [kht_pkg::SLOT_IDX_W-1:0]      rsp_slot_index,
   // configuration port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [kht_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [kht_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [kht_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import kht_pkg::*;

   logic [CAP_LOG2_W-1:0] cap_log2_ff;
   logic                  csr_wr;
   logic                  csr_sel_cap;
   kht_cmd_type           cmd;
   kht_sts_type           sts;

   // register file: one word, capacity_log2
   assign pready      = 1'b1;
   assign csr_sel_cap = (paddr[CSR_ADDR_W-1] == REG_CAP_LOG2);
   assign csr_wr      = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_log2_ff <= CAP_LOG2_RESET;
      end else if (csr_wr && csr_sel_cap) begin
         cap_log2_ff <= pwdata[CAP_LOG2_W-1:0];
      end
   end

   assign prdata = csr_sel_cap ? CSR_DATA_W'(cap_log2_ff) : '0;

   kht_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_byte (req_last_byte),
      .sts           (sts),
      .cmd           (cmd),
      .busy          (busy)
   );

   kht_datapath #(
      .MAX_SLOTS     (MAX_SLOTS),
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .TOKEN_BITS    (TOKEN_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_key_byte     (req_key_byte),
      .req_token_value  (req_token_value),
      .cap_log2         (cap_log2_ff),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_token_result (rsp_token_result),
      .rsp_slot_index   (rsp_slot_index)
   );

endmodule : keyword_hash_table_lookup_top
`default_nettype wire
